/* rtl/sre_pkg.sv */
// Shared constants, opcodes and stage types for the small RISC executor.
package sre_pkg;

    localparam int NUM_REGS   = 16;
    localparam int DATA_WORDS = 4096;

    localparam int XLEN  = 32;
    localparam int PC_W  = 16;
    localparam int IMM_W = 16;
    localparam int IDX_W = 4;
    localparam int CMD_W = 5;

    localparam int REG_AW  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int DATA_AW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;

    localparam int PC_STEP = 4;

    typedef enum logic [CMD_W-1:0] {
        OP_MOVC  = 5'd0,
        OP_ADD   = 5'd1,
        OP_ADDL  = 5'd2,
        OP_SUB   = 5'd3,
        OP_SUBL  = 5'd4,
        OP_MUL   = 5'd5,
        OP_AND   = 5'd6,
        OP_OR    = 5'd7,
        OP_XOR   = 5'd8,
        OP_LOAD  = 5'd9,
        OP_STORE = 5'd10,
        OP_LDR   = 5'd11,
        OP_STR   = 5'd12,
        OP_BZ    = 5'd13,
        OP_BNZ   = 5'd14,
        OP_JUMP  = 5'd15,
        OP_HALT  = 5'd16,
        OP_NOP   = 5'd17
    } op_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [IDX_W-1:0] dest_reg;
        logic [IDX_W-1:0] src_a;
        logic [IDX_W-1:0] src_b;
        logic [IDX_W-1:0] src_c;
        logic [IMM_W-1:0] immediate;
        logic [PC_W-1:0]  instr_pc;
    } instr_t;

    typedef struct packed {
        logic [PC_W-1:0]  next_pc;
        logic             branch_taken;
        logic             reg_written;
        logic [IDX_W-1:0] write_index;
        logic [XLEN-1:0]  alu_val;
        logic             is_load;
        logic             sets_z;
        logic             address_fault;
        logic             halted;
    } s2_t;

    typedef struct packed {
        logic [PC_W-1:0]  next_pc;
        logic             branch_taken;
        logic             reg_written;
        logic [IDX_W-1:0] write_index;
        logic [XLEN-1:0]  write_value;
        logic             zero_flag;
        logic             address_fault;
        logic             halted;
    } result_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx_a;
        logic [IDX_W-1:0] idx_b;
        logic [IDX_W-1:0] idx_c;
    } rf_rd_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [XLEN-1:0]  data;
    } rf_wr_t;

    typedef struct packed {
        logic               rd_en;
        logic               wr_en;
        logic [DATA_AW-1:0] addr;
        logic [XLEN-1:0]    wdata;
    } dm_req_t;

endpackage

/* rtl/sre_in_if.sv */
// Instruction channel: valid/ready handshake with one decoded instruction.
interface sre_in_if import sre_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        cmd;
    logic [IDX_W-1:0]        dest_reg;
    logic [IDX_W-1:0]        src_a;
    logic [IDX_W-1:0]        src_b;
    logic [IDX_W-1:0]        src_c;
    logic signed [IMM_W-1:0] immediate;
    logic [PC_W-1:0]         instr_pc;

    modport source (
        output valid, cmd, dest_reg, src_a, src_b, src_c, immediate, instr_pc,
        input  ready
    );

    modport sink (
        input  valid, cmd, dest_reg, src_a, src_b, src_c, immediate, instr_pc,
        output ready
    );

endinterface

/* rtl/sre_out_if.sv */
// Result channel: valid/ready handshake with one executed-instruction result.
interface sre_out_if import sre_pkg::*; ();

    logic                   valid;
    logic                   ready;
    logic [PC_W-1:0]        next_pc;
    logic                   branch_taken;
    logic                   reg_written;
    logic [IDX_W-1:0]       write_index;
    logic signed [XLEN-1:0] write_value;
    logic                   zero_flag;
    logic                   address_fault;
    logic                   halted;

    modport source (
        output valid, next_pc, branch_taken, reg_written, write_index, write_value,
               zero_flag, address_fault, halted,
        input  ready
    );

    modport sink (
        input  valid, next_pc, branch_taken, reg_written, write_index, write_value,
               zero_flag, address_fault, halted,
        output ready
    );

endinterface

/* rtl/sre_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
module sre_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read returns the old contents when the same entry is written in that cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/sre_regfile.sv */
// Register file: three read banks with a shared write port and per-entry valid bits.
module sre_regfile import sre_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  rf_rd_t          rd_req,
    input  rf_wr_t          wr_req,
    output logic [XLEN-1:0] va,
    output logic [XLEN-1:0] vb,
    output logic [XLEN-1:0] vc
);

    logic [2:0][IDX_W-1:0]  idx;
    logic [2:0][REG_AW-1:0] raddr;
    logic [2:0][XLEN-1:0]   rdata;
    logic [REG_AW-1:0]      waddr;
    logic [NUM_REGS-1:0]    valid_reg;
    logic [NUM_REGS-1:0]    valid_next;
    logic [2:0]             live_reg;
    logic [2:0]             live_next;

    assign idx   = {rd_req.idx_c, rd_req.idx_b, rd_req.idx_a};
    assign waddr = REG_AW'(wr_req.idx);

    for (genvar p = 0; p < 3; p++)
    begin : g_bank
        assign raddr[p] = REG_AW'(idx[p]);

        sre_ram #(
            .WIDTH (XLEN),
            .DEPTH (NUM_REGS)
        ) u_bank (
            .clk   (clk),
            .we    (wr_req.en),
            .waddr (waddr),
            .wdata (wr_req.data),
            .re    (rd_req.en),
            .raddr (raddr[p]),
            .rdata (rdata[p])
        );
    end

    // An entry never written since reset, or an index past the file, reads as zero.
    always_comb
    begin
        valid_next = valid_reg;
        live_next  = live_reg;
        if (rd_req.en)
        begin
            for (int p = 0; p < 3; p++)
            begin
                live_next[p] = (32'(idx[p]) < 32'(NUM_REGS)) && valid_reg[raddr[p]];
            end
        end
        if (wr_req.en)
        begin
            valid_next[waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            live_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            live_reg  <= live_next;
        end
    end

    assign va = live_reg[0] ? rdata[0] : '0;
    assign vb = live_reg[1] ? rdata[1] : '0;
    assign vc = live_reg[2] ? rdata[2] : '0;

endmodule

/* rtl/sre_dmem.sv */
// Data memory with the clearing sweep that runs after reset.
module sre_dmem import sre_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  dm_req_t         req,
    output logic [XLEN-1:0] rdata,
    output logic            busy
);

    logic               clear_reg;
    logic               clear_next;
    logic [DATA_AW-1:0] cnt_reg;
    logic [DATA_AW-1:0] cnt_next;
    logic               we;
    logic [DATA_AW-1:0] waddr;
    logic [XLEN-1:0]    wdata;

    always_comb
    begin
        clear_next = clear_reg;
        cnt_next   = cnt_reg;
        if (clear_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DATA_AW'(DATA_WORDS - 1))
            begin
                clear_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg <= 1'b1;
            cnt_reg   <= '0;
        end
        else
        begin
            clear_reg <= clear_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Sweep owns the write port until every word holds zero.
    assign we    = clear_reg || req.wr_en;
    assign waddr = clear_reg ? cnt_reg : req.addr;
    assign wdata = clear_reg ? '0 : req.wdata;

    sre_ram #(
        .WIDTH (XLEN),
        .DEPTH (DATA_WORDS)
    ) u_mem (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (req.rd_en),
        .raddr (req.addr),
        .rdata (rdata)
    );

    assign busy = clear_reg;

endmodule

/* rtl/small_risc_instruction_executor.sv */
// Top level: three-stage in-order executor around the register file and data memory.
//
// Each accepted item is one decoded instruction; it passes through stage one,
// stage two and the output register, taken one per cycle while nothing stalls.
// Stage one reads the three register banks, stage two executes with full
// forwarding from the two older stages (including load data) and drives the
// data-memory port, stage three is the output register where the register file
// and zero flag are updated. Only back-pressure on the result channel and the
// reset sweep slow the stream: after reset the data memory is swept to zero, one
// word per cycle, over all DATA_WORDS (4096) words, while instr.ready stays low.
module small_risc_instruction_executor import sre_pkg::*; (
    input logic   clk,
    input logic   rst_n,
    sre_in_if.sink    instr,
    sre_out_if.source result
);

    function automatic logic [XLEN-1:0] fwd_val(
        input logic [IDX_W-1:0] idx,
        input logic [XLEN-1:0]  rf_val,
        input logic             s2_hit,
        input logic [IDX_W-1:0] s2_idx,
        input logic [XLEN-1:0]  s2_val,
        input logic             o_hit,
        input logic [IDX_W-1:0] o_idx,
        input logic [XLEN-1:0]  o_val
    );
        logic [XLEN-1:0] v;
        if (s2_hit && (s2_idx == idx))
        begin
            v = s2_val;
        end
        else if (o_hit && (o_idx == idx))
        begin
            v = o_val;
        end
        else
        begin
            v = rf_val;
        end
        return v;
    endfunction

    logic            dm_busy;
    logic            accept;
    logic            out_free;
    logic            s2_free;
    logic            s1_free;
    logic            s1_move;
    logic            s2_move;

    logic            s1_valid_reg;
    logic            s1_valid_next;
    instr_t          s1_reg;
    instr_t          s1_next;
    logic            s2_valid_reg;
    logic            s2_valid_next;
    s2_t             s2_reg;
    s2_t             s2_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    result_t         out_reg;
    result_t         out_next;
    logic            zflag_reg;
    logic            zflag_next;

    rf_rd_t          rf_rd;
    rf_wr_t          rf_wr;
    dm_req_t         dm_req;
    logic [XLEN-1:0] rf_va;
    logic [XLEN-1:0] rf_vb;
    logic [XLEN-1:0] rf_vc;
    logic [XLEN-1:0] dm_rdata;

    logic [XLEN-1:0] s2_final;
    logic            s2_zero;
    logic            s2_fwd;
    logic            o_fwd;
    logic            zflag_cur;

    logic [XLEN-1:0] va;
    logic [XLEN-1:0] vb;
    logic [XLEN-1:0] vc;
    logic [XLEN-1:0] imm32;
    logic [XLEN-1:0] sum_ai;
    logic [XLEN-1:0] prod;
    logic [XLEN-1:0] mem_base;
    logic [XLEN-1:0] mem_off;
    logic [XLEN-1:0] mem_addr;
    logic            addr_ok;
    logic            is_store;
    logic [PC_W-1:0] pc_seq;
    logic [PC_W-1:0] pc_rel;

    // Handshake chain: each stage frees up when the one ahead moves on.
    assign out_free    = !out_valid_reg || result.ready;
    assign s2_free     = !s2_valid_reg || out_free;
    assign s1_free     = !s1_valid_reg || s2_free;
    assign s1_move     = s1_valid_reg && s2_free;
    assign s2_move     = s2_valid_reg && out_free;
    assign instr.ready = s1_free && !dm_busy;
    assign accept      = instr.valid && instr.ready;

    assign s1_next = '{
        cmd:       instr.cmd,
        dest_reg:  instr.dest_reg,
        src_a:     instr.src_a,
        src_b:     instr.src_b,
        src_c:     instr.src_c,
        immediate: instr.immediate,
        instr_pc:  instr.instr_pc
    };

    assign rf_rd = '{en: accept, idx_a: instr.src_a, idx_b: instr.src_b, idx_c: instr.src_c};

    sre_regfile u_regfile (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_req (rf_rd),
        .wr_req (rf_wr),
        .va     (rf_va),
        .vb     (rf_vb),
        .vc     (rf_vc)
    );

    sre_dmem u_dmem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dm_req),
        .rdata (dm_rdata),
        .busy  (dm_busy)
    );

    // Stage two value and flag, as seen by the stage behind it.
    assign s2_final  = s2_reg.is_load ? dm_rdata : s2_reg.alu_val;
    assign s2_zero   = s2_reg.sets_z ? (s2_reg.alu_val == '0) : zflag_reg;
    assign s2_fwd    = s2_valid_reg && s2_reg.reg_written;
    assign o_fwd     = out_valid_reg && out_reg.reg_written;
    assign zflag_cur = (s2_valid_reg && s2_reg.sets_z) ? (s2_reg.alu_val == '0) : zflag_reg;

    assign va = fwd_val(s1_reg.src_a, rf_va, s2_fwd, s2_reg.write_index, s2_final,
                        o_fwd, out_reg.write_index, out_reg.write_value);
    assign vb = fwd_val(s1_reg.src_b, rf_vb, s2_fwd, s2_reg.write_index, s2_final,
                        o_fwd, out_reg.write_index, out_reg.write_value);
    assign vc = fwd_val(s1_reg.src_c, rf_vc, s2_fwd, s2_reg.write_index, s2_final,
                        o_fwd, out_reg.write_index, out_reg.write_value);

    assign imm32  = {{(XLEN-IMM_W){s1_reg.immediate[IMM_W-1]}}, s1_reg.immediate};
    assign sum_ai = va + imm32;
    assign prod   = va * vb;
    assign pc_seq = s1_reg.instr_pc + PC_W'(PC_STEP);
    assign pc_rel = s1_reg.instr_pc + s1_reg.immediate;

    assign is_store = (s1_reg.cmd == OP_STORE) || (s1_reg.cmd == OP_STR);
    assign mem_base = is_store ? vb : va;
    assign mem_off  = ((s1_reg.cmd == OP_LOAD) || (s1_reg.cmd == OP_STORE)) ? imm32 :
                      ((s1_reg.cmd == OP_LDR) ? vb : vc);
    assign mem_addr = mem_base + mem_off;
    assign addr_ok  = mem_addr < XLEN'(DATA_WORDS);

    always_comb
    begin
        s2_next = '{
            next_pc:       pc_seq,
            branch_taken:  1'b0,
            reg_written:   1'b0,
            write_index:   s1_reg.dest_reg,
            alu_val:       '0,
            is_load:       1'b0,
            sets_z:        1'b0,
            address_fault: 1'b0,
            halted:        1'b0
        };
        unique case (s1_reg.cmd)
            OP_MOVC:
            begin
                s2_next.reg_written = 1'b1;
                s2_next.alu_val     = imm32;
            end
            OP_ADD:
            begin
                s2_next.reg_written = 1'b1;
                s2_next.alu_val     = va + vb;
                s2_next.sets_z      = 1'b1;
            end
            OP_ADDL:
            begin
                s2_next.reg_written = 1'b1;
                s2_next.alu_val     = sum_ai;
                s2_next.sets_z      = 1'b1;
            end
            OP_SUB:
            begin
                s2_next.reg_written = 1'b1;
                s2_next.alu_val     = va - vb;
                s2_next.sets_z      = 1'b1;
            end
            OP_SUBL:
            begin
                s2_next.reg_written = 1'b1;
                s2_next.alu_val     = va - imm32;
                s2_next.sets_z      = 1'b1;
            end
            OP_MUL:
            begin
                s2_next.reg_written = 1'b1;
                s2_next.alu_val     = prod;
                s2_next.sets_z      = 1'b1;
            end
            OP_AND:
            begin
                s2_next.reg_written = 1'b1;
                s2_next.alu_val     = va & vb;
            end
            OP_OR:
            begin
                s2_next.reg_written = 1'b1;
                s2_next.alu_val     = va | vb;
            end
            OP_XOR:
            begin
                s2_next.reg_written = 1'b1;
                s2_next.alu_val     = va ^ vb;
            end
            OP_LOAD, OP_LDR:
            begin
                s2_next.reg_written   = addr_ok;
                s2_next.is_load       = addr_ok;
                s2_next.address_fault = !addr_ok;
            end
            OP_STORE, OP_STR:
            begin
                s2_next.address_fault = !addr_ok;
            end
            OP_BZ:
            begin
                if (zflag_cur)
                begin
                    s2_next.branch_taken = 1'b1;
                    s2_next.next_pc      = pc_rel;
                end
            end
            OP_BNZ:
            begin
                if (!zflag_cur)
                begin
                    s2_next.branch_taken = 1'b1;
                    s2_next.next_pc      = pc_rel;
                end
            end
            OP_JUMP:
            begin
                s2_next.branch_taken = 1'b1;
                s2_next.next_pc      = sum_ai[PC_W-1:0];
            end
            OP_HALT:
            begin
                s2_next.halted = 1'b1;
            end
            default:
            begin
                s2_next.halted = 1'b0;
            end
        endcase
        // Drop writes to registers past the end of the file.
        if (32'(s1_reg.dest_reg) >= 32'(NUM_REGS))
        begin
            s2_next.reg_written = 1'b0;
        end
    end

    assign dm_req = '{
        rd_en: s1_move && s2_next.is_load,
        wr_en: s1_move && is_store && addr_ok,
        addr:  mem_addr[DATA_AW-1:0],
        wdata: va
    };

    // Retire: update architectural state as the item enters the output register.
    assign rf_wr = '{
        en:   s2_move && s2_reg.reg_written,
        idx:  s2_reg.write_index,
        data: s2_final
    };

    assign out_next = '{
        next_pc:       s2_reg.next_pc,
        branch_taken:  s2_reg.branch_taken,
        reg_written:   s2_reg.reg_written,
        write_index:   s2_reg.reg_written ? s2_reg.write_index : '0,
        write_value:   s2_reg.reg_written ? s2_final : '0,
        zero_flag:     s2_zero,
        address_fault: s2_reg.address_fault,
        halted:        s2_reg.halted
    };

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s2_valid_next  = s2_valid_reg;
        out_valid_next = out_valid_reg;
        zflag_next     = zflag_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
        if (s1_move)
        begin
            s2_valid_next = 1'b1;
        end
        else if (s2_move)
        begin
            s2_valid_next = 1'b0;
        end
        if (s2_move)
        begin
            out_valid_next = 1'b1;
            zflag_next     = s2_zero;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            zflag_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            zflag_reg     <= zflag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
        if (s1_move)
        begin
            s2_reg <= s2_next;
        end
        if (s2_move)
        begin
            out_reg <= out_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.next_pc       = out_reg.next_pc;
    assign result.branch_taken  = out_reg.branch_taken;
    assign result.reg_written   = out_reg.reg_written;
    assign result.write_index   = out_reg.write_index;
    assign result.write_value   = out_reg.write_value;
    assign result.zero_flag     = out_reg.zero_flag;
    assign result.address_fault = out_reg.address_fault;
    assign result.halted        = out_reg.halted;

endmodule

/* rtl/sre_checker.sv */
// Port-level checks on the executor, attached to the top level by bind.
module sre_checker import sre_pkg::*; (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            out_valid,
    input logic            out_ready,
    input logic [PC_W-1:0] next_pc,
    input logic            branch_taken,
    input logic            reg_written,
    input logic [IDX_W-1:0] write_index,
    input logic [XLEN-1:0] write_value,
    input logic            address_fault,
    input logic            halted
);

    logic [2:0] pending_reg;
    logic [2:0] pending_next;

    // Items accepted and not yet delivered.
    always_comb
    begin
        pending_next = pending_reg + 3'(in_valid && in_ready) - 3'(out_valid && out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pending_reg != 3'd0))
        else $error("result shown with no item in flight");

    a_bounded_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd3)
        else $error("more items in flight than pipeline stages");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(next_pc) && $stable(write_value)
            && $stable(write_index) && $stable(reg_written))
        else $error("stalled result changed");

    a_no_write_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !reg_written |-> (write_index == '0) && (write_value == '0))
        else $error("write fields nonzero without a register write");

    a_fault_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (halted || address_fault) |-> !reg_written && !branch_taken
            && !(halted && address_fault))
        else $error("halt or fault result with side effects");

endmodule

bind small_risc_instruction_executor sre_checker u_sre_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (instr.valid),
    .in_ready      (instr.ready),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .next_pc       (result.next_pc),
    .branch_taken  (result.branch_taken),
    .reg_written   (result.reg_written),
    .write_index   (result.write_index),
    .write_value   (result.write_value),
    .address_fault (result.address_fault),
    .halted        (result.halted)
);
